FILE: design/pnsc_pkg.sv
// Shared types and constants for the Potts neighbor spin candidate picker.
`timescale 1ns / 1ps

package pnsc_pkg;

   // Width of every spin field on the ports
   localparam int FIELD_W = 16;
   // Number of neighbors around one site
   localparam int NUM_NEIGH = 8;
   // Width of a neighbor count, 0..8
   localparam int COUNT_W = 4;
   // Width of a position among candidates, 0..7
   localparam int POS_W = 3;

   // Input beat: one site and its neighborhood
   typedef struct packed {
      logic [FIELD_W-1:0] center_spin;
      logic [FIELD_W-1:0] spin_nw;
      logic [FIELD_W-1:0] spin_n;
      logic [FIELD_W-1:0] spin_ne;
      logic [FIELD_W-1:0] spin_w;
      logic [FIELD_W-1:0] spin_e;
      logic [FIELD_W-1:0] spin_sw;
      logic [FIELD_W-1:0] spin_s;
      logic [FIELD_W-1:0] spin_se;
      logic [FIELD_W-1:0] rand_frac;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [COUNT_W-1:0] candidate_count;
      logic [FIELD_W-1:0] new_spin;
      logic               no_candidate;
   } rsp_type;

   // After the compare stage: masked spins and all equality flags
   typedef struct packed {
      logic [NUM_NEIGH-1:0][FIELD_W-1:0] spin;
      logic [FIELD_W-1:0]                center;
      logic [FIELD_W-1:0]                rand_frac;
      logic [NUM_NEIGH-1:0]              differs;
      logic [NUM_NEIGH-1:0][NUM_NEIGH-1:0] eq;
   } s1_type;

   // After the tally stage: first occurrences and their counts
   typedef struct packed {
      logic [NUM_NEIGH-1:0][FIELD_W-1:0] spin;
      logic [FIELD_W-1:0]                center;
      logic [FIELD_W-1:0]                rand_frac;
      logic [NUM_NEIGH-1:0]              first;
      logic [NUM_NEIGH-1:0][COUNT_W-1:0] tally;
      logic [COUNT_W-1:0]                same;
   } s2_type;

   // After the candidate stage: candidate mask, count and ranks
   typedef struct packed {
      logic [NUM_NEIGH-1:0][FIELD_W-1:0] spin;
      logic [FIELD_W-1:0]                center;
      logic [FIELD_W-1:0]                rand_frac;
      logic [NUM_NEIGH-1:0]              cand;
      logic [COUNT_W-1:0]                ncand;
      logic [NUM_NEIGH-1:0][POS_W-1:0]   pos;
   } s3_type;

   // Handshake pair between two stages
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

FILE: design/potts_neighbor_spin_candidate_pick_top.sv
// Top level of the Potts neighbor spin candidate picker pipeline.
//
//   port group   | direction | beat contents
//   req_*        | in        | req_type: center, eight neighbors, rand_frac
//   rsp_*        | out       | rsp_type: candidate_count, new_spin, no_candidate
//
// Four register stages (compare, tally, rank, select); a req beat passes
// through them in that order and its rsp beat is shown from the select
// register. One beat can enter every cycle while rsp_stall is low; throughput
// is one beat per cycle, set by the per-stage valid/ready chain.
// Reset is synchronous and clears only the stage valid bits.
// rsp_stall holds the output register; upstream stages keep filling their
// empty slots, and req_stall rises only when every stage holds a beat.
`timescale 1ns / 1ps

module potts_neighbor_spin_candidate_pick_top #(
   parameter int SPIN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pnsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pnsc_pkg::rsp_type rsp_data
);

   pnsc_pkg::hs_type h1;
   pnsc_pkg::hs_type h2;
   pnsc_pkg::hs_type h3;
   pnsc_pkg::s1_type d1;
   pnsc_pkg::s2_type d2;
   pnsc_pkg::s3_type d3;
   logic             req_ready;

   assign req_stall = !req_ready;

   pnsc_compare #(
      .SPIN_BITS (SPIN_BITS)
   ) u_compare (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (h1.valid),
      .out_ready (h1.ready),
      .out_data  (d1)
   );

   pnsc_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h1.valid),
      .in_ready  (h1.ready),
      .in_data   (d1),
      .out_valid (h2.valid),
      .out_ready (h2.ready),
      .out_data  (d2)
   );

   pnsc_rank u_rank (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h2.valid),
      .in_ready  (h2.ready),
      .in_data   (d2),
      .out_valid (h3.valid),
      .out_ready (h3.ready),
      .out_data  (d3)
   );

   pnsc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h3.valid),
      .in_ready  (h3.ready),
      .in_data   (d3),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

FILE: design/pnsc_compare.sv
// Stage 1: spin masking and pairwise equality compares.
`timescale 1ns / 1ps

module pnsc_compare #(
   parameter int SPIN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pnsc_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pnsc_pkg::s1_type  out_data
);

   localparam int CMP_BITS = (SPIN_BITS < pnsc_pkg::FIELD_W) ? SPIN_BITS : pnsc_pkg::FIELD_W;
   localparam logic [pnsc_pkg::FIELD_W-1:0] SPIN_MASK =
      pnsc_pkg::FIELD_W'((33'd1 << CMP_BITS) - 33'd1);

   logic                                                  valid_ff;
   pnsc_pkg::s1_type                                      data_ff;
   pnsc_pkg::s1_type                                      data_in;
   logic [pnsc_pkg::NUM_NEIGH-1:0][pnsc_pkg::FIELD_W-1:0] raw;

   // neighbors in NW, N, NE, W, E, SW, S, SE order
   assign raw[0] = in_data.spin_nw;
   assign raw[1] = in_data.spin_n;
   assign raw[2] = in_data.spin_ne;
   assign raw[3] = in_data.spin_w;
   assign raw[4] = in_data.spin_e;
   assign raw[5] = in_data.spin_sw;
   assign raw[6] = in_data.spin_s;
   assign raw[7] = in_data.spin_se;

   // mask spins, compare each against the center and against each other
   always_comb begin
      data_in.center    = in_data.center_spin & SPIN_MASK;
      data_in.rand_frac = in_data.rand_frac;
      for (int k = 0; k < pnsc_pkg::NUM_NEIGH; k++) begin
         data_in.spin[k] = raw[k] & SPIN_MASK;
      end
      for (int k = 0; k < pnsc_pkg::NUM_NEIGH; k++) begin
         data_in.differs[k] = (data_in.spin[k] != data_in.center);
         for (int j = 0; j < pnsc_pkg::NUM_NEIGH; j++) begin
            data_in.eq[k][j] = (data_in.spin[k] == data_in.spin[j]);
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/pnsc_tally.sv
// Stage 2: first-occurrence marks and per-spin neighbor tallies.
`timescale 1ns / 1ps

module pnsc_tally (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pnsc_pkg::s1_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pnsc_pkg::s2_type out_data
);

   logic             valid_ff;
   pnsc_pkg::s2_type data_ff;
   pnsc_pkg::s2_type data_in;
   logic             seen;

   // a differing spin is listed at its first position; its tally counts all equal neighbors
   always_comb begin
      data_in.spin      = in_data.spin;
      data_in.center    = in_data.center;
      data_in.rand_frac = in_data.rand_frac;
      data_in.same      = '0;
      for (int k = 0; k < pnsc_pkg::NUM_NEIGH; k++) begin
         data_in.same = data_in.same + pnsc_pkg::COUNT_W'(!in_data.differs[k]);
      end
      for (int k = 0; k < pnsc_pkg::NUM_NEIGH; k++) begin
         seen = 1'b0;
         data_in.tally[k] = '0;
         for (int j = 0; j < pnsc_pkg::NUM_NEIGH; j++) begin
            if (j < k) begin
               seen = seen | in_data.eq[k][j];
            end
            data_in.tally[k] = data_in.tally[k] + pnsc_pkg::COUNT_W'(in_data.eq[k][j]);
         end
         data_in.first[k] = in_data.differs[k] && !seen;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/pnsc_rank.sv
// Stage 3: candidate test, candidate count and rank of each candidate.
`timescale 1ns / 1ps

module pnsc_rank (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pnsc_pkg::s2_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pnsc_pkg::s3_type out_data
);

   logic                        valid_ff;
   pnsc_pkg::s3_type            data_ff;
   pnsc_pkg::s3_type            data_in;
   logic [pnsc_pkg::COUNT_W-1:0] run;

   // candidate when its tally reaches the center's tally; rank is a running count
   always_comb begin
      data_in.spin      = in_data.spin;
      data_in.center    = in_data.center;
      data_in.rand_frac = in_data.rand_frac;
      run = '0;
      for (int k = 0; k < pnsc_pkg::NUM_NEIGH; k++) begin
         data_in.cand[k] = in_data.first[k] && (in_data.tally[k] >= in_data.same);
         data_in.pos[k]  = run[pnsc_pkg::POS_W-1:0];
         run = run + pnsc_pkg::COUNT_W'(data_in.cand[k]);
      end
      data_in.ncand = run;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/pnsc_select.sv
// Stage 4: random index scaling, candidate pick and result register.
`timescale 1ns / 1ps

module pnsc_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pnsc_pkg::s3_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pnsc_pkg::rsp_type out_data
);

   localparam int PROD_W = pnsc_pkg::FIELD_W + pnsc_pkg::COUNT_W;

   logic                          valid_ff;
   pnsc_pkg::rsp_type             data_ff;
   pnsc_pkg::rsp_type             data_in;
   logic [PROD_W-1:0]             prod;
   logic [pnsc_pkg::POS_W-1:0]    idx;
   logic [pnsc_pkg::FIELD_W-1:0]  picked;
   logic [pnsc_pkg::FIELD_W-1:0]  center_ff;

   // index = floor(rand * count / 2^16); count <= 8 keeps it below count
   assign prod = PROD_W'(in_data.rand_frac) * PROD_W'(in_data.ncand);
   assign idx  = prod[pnsc_pkg::FIELD_W +: pnsc_pkg::POS_W];

   // one-hot pick of the candidate whose rank equals the index
   always_comb begin
      picked = '0;
      for (int k = 0; k < pnsc_pkg::NUM_NEIGH; k++) begin
         if (in_data.cand[k] && (in_data.pos[k] == idx)) begin
            picked = picked | in_data.spin[k];
         end
      end
      data_in.candidate_count = in_data.ncand;
      data_in.no_candidate    = (in_data.ncand == '0);
      data_in.new_spin        = data_in.no_candidate ? in_data.center : picked;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff   <= data_in;
         center_ff <= in_data.center;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // flag and count agree
   a_flag_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.no_candidate == (data_ff.candidate_count == '0)))
      else $error("no_candidate disagrees with candidate_count");

   // at most eight candidates
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.candidate_count <= pnsc_pkg::COUNT_W'(pnsc_pkg::NUM_NEIGH)))
      else $error("candidate_count above eight");

   // an empty candidate list keeps the center spin
   a_keep_center: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.no_candidate) |-> (data_ff.new_spin == center_ff))
      else $error("new_spin differs from center with no candidate");

   // a picked candidate never equals the center spin
   a_pick_differs: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !data_ff.no_candidate) |-> (data_ff.new_spin != center_ff))
      else $error("picked spin equals center spin");

endmodule
